>>> rtl/subnet_scope_table_lookup_defines.svh
// Assertion helpers for the scope table checks.
`ifndef SUBNET_SCOPE_TABLE_LOOKUP_DEFINES_SVH
`define SUBNET_SCOPE_TABLE_LOOKUP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sstl_pkg.sv
package sstl_pkg;

  localparam int ADDR_W          = 32;
  localparam int KIND_W          = 2;
  localparam int SLOT_W          = 4;
  localparam int TABLE_DEPTH_DEF = 16;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [SLOT_W-1:0] slot_t;

  // Operation codes of an input word
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_LOOKUP = 2'd1;
  localparam kind_t KIND_CLEAR  = 2'd2;
  localparam kind_t KIND_NOP    = 2'd3;

  // Status codes of a result word
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

>>> rtl/sstl_if.sv
// Request channel
interface sstl_in_if import sstl_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t kind;
  addr_t address;
  addr_t subnet_mask;
  addr_t iface_index;

  modport source (output valid, kind, address, subnet_mask, iface_index, input ready);
  modport sink   (input valid, kind, address, subnet_mask, iface_index, output ready);
endinterface

// Result channel
interface sstl_out_if import sstl_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  status;
  logic  found;
  logic  exact_iface;
  slot_t entry_slot;
  addr_t net_address;
  addr_t entry_mask;
  addr_t entry_iface;
  addr_t bcast_address;
  addr_t host_min;
  addr_t host_max;

  modport source (output valid, status, found, exact_iface, entry_slot, net_address,
                  entry_mask, entry_iface, bcast_address, host_min, host_max,
                  input ready);
  modport sink   (input valid, status, found, exact_iface, entry_slot, net_address,
                  entry_mask, entry_iface, bcast_address, host_min, host_max,
                  output ready);
endinterface

>>> rtl/subnet_scope_table_lookup.sv
// Flow: insert, clear and no-op words go from idle to the description state, which loads the
//   result once the output is free; a lookup first scans a nonempty table, stopping early on
//   an exact interface match. The scan reads one table entry per cycle from a single RAM port.
// Throughput: one word at a time; ready is high only while the sequencer is idle,
//   and a finished result may wait in the output register while the next word is taken.
// Reset (rst_n low, synchronous): entry count zero, sequencer idle, no result pending.
module subnet_scope_table_lookup import sstl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sstl_in_if.sink     in_ch,
  sstl_out_if.source  out_ch
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = 3 * ADDR_W;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DESC = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             have_r, have_nxt;
  logic             exact_r, exact_nxt;
  logic             full_r, full_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  addr_t            req_addr_r, req_addr_nxt;
  addr_t            req_iface_r, req_iface_nxt;
  addr_t            sel_addr_r, sel_addr_nxt;
  addr_t            sel_mask_r, sel_mask_nxt;
  addr_t            sel_iface_r, sel_iface_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             accept;
  logic             ram_we;
  logic             ram_re;
  logic [ENT_W-1:0] ram_rdata;
  addr_t            d_addr, d_mask, d_iface;
  logic             hit, exact_hit, last_cmp;
  logic             out_load;
  addr_t            net, bcast, first_h, last_h;
  logic             wide_range;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // Table storage: {address, mask, iface} per entry
  assign ram_we = accept && (in_ch.kind == KIND_INSERT) && (count_r < CNT_W'(TABLE_DEPTH));
  assign ram_re = (state_r == ST_SCAN) && (iss_r < count_r);

  sstl_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata ({in_ch.address, in_ch.subnet_mask, in_ch.iface_index}),
    .re    (ram_re),
    .raddr (iss_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign d_addr  = ram_rdata[3*ADDR_W-1:2*ADDR_W];
  assign d_mask  = ram_rdata[2*ADDR_W-1:ADDR_W];
  assign d_iface = ram_rdata[ADDR_W-1:0];

  // Shared compare unit: subnet match and interface match of the entry just read
  assign hit       = ((req_addr_r & d_mask) == (d_addr & d_mask));
  assign exact_hit = hit && (d_iface == req_iface_r);
  assign last_cmp  = ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == count_r);

  // Scope description of the selected entry
  assign net        = sel_addr_r & sel_mask_r;
  assign bcast      = sel_addr_r | ~sel_mask_r;
  assign wide_range = ({1'b0, bcast} > ({1'b0, net} + (ADDR_W+1)'(1)));
  assign first_h    = wide_range ? (net + ADDR_W'(1)) : sel_addr_r;
  assign last_h     = wide_range ? (bcast - ADDR_W'(1)) : sel_addr_r;

  assign out_load = (state_r == ST_DESC) && (!out_valid_r || out_ch.ready);

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    iss_nxt       = iss_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    have_nxt      = have_r;
    exact_nxt     = exact_r;
    full_nxt      = full_r;
    pick_nxt      = pick_r;
    req_addr_nxt  = req_addr_r;
    req_iface_nxt = req_iface_r;
    sel_addr_nxt  = sel_addr_r;
    sel_mask_nxt  = sel_mask_r;
    sel_iface_nxt = sel_iface_r;
    out_valid_nxt = out_valid_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          have_nxt      = 1'b0;
          exact_nxt     = 1'b0;
          full_nxt      = 1'b0;
          iss_nxt       = '0;
          req_addr_nxt  = in_ch.address;
          req_iface_nxt = in_ch.iface_index;
          state_nxt     = ST_DESC;
          case (in_ch.kind)
            KIND_INSERT: begin
              if (ram_we) begin
                have_nxt      = 1'b1;
                pick_nxt      = count_r[IDX_W-1:0];
                sel_addr_nxt  = in_ch.address;
                sel_mask_nxt  = in_ch.subnet_mask;
                sel_iface_nxt = in_ch.iface_index;
                count_nxt     = count_r + CNT_W'(1);
              end else begin
                full_nxt = 1'b1;
              end
            end
            KIND_LOOKUP: begin
              if (count_r != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            KIND_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // issue side
        if (ram_re) begin
          iss_nxt     = iss_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = iss_r[IDX_W-1:0];
        end
        // compare side
        if (cmp_vld_r) begin
          if (exact_hit || (hit && !have_r)) begin
            have_nxt      = 1'b1;
            exact_nxt     = exact_hit;
            pick_nxt      = cmp_idx_r;
            sel_addr_nxt  = d_addr;
            sel_mask_nxt  = d_mask;
            sel_iface_nxt = d_iface;
          end
          if (exact_hit || last_cmp) begin
            state_nxt   = ST_DESC;
            cmp_vld_nxt = 1'b0;
          end
        end
      end
      ST_DESC: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    iss_r       <= iss_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    have_r      <= have_nxt;
    exact_r     <= exact_nxt;
    full_r      <= full_nxt;
    pick_r      <= pick_nxt;
    req_addr_r  <= req_addr_nxt;
    req_iface_r <= req_iface_nxt;
    sel_addr_r  <= sel_addr_nxt;
    sel_mask_r  <= sel_mask_nxt;
    sel_iface_r <= sel_iface_nxt;
  end

  // Result register
  logic  status_r, found_r, exact_out_r;
  slot_t slot_r;
  addr_t net_r, mask_r, iface_r, bcast_r, first_r, last_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r    <= full_r ? STATUS_FULL : STATUS_OK;
      found_r     <= have_r;
      exact_out_r <= have_r && exact_r;
      slot_r      <= have_r ? SLOT_W'(pick_r) : '0;
      net_r       <= have_r ? net : '0;
      mask_r      <= have_r ? sel_mask_r : '0;
      iface_r     <= have_r ? sel_iface_r : '0;
      bcast_r     <= have_r ? bcast : '0;
      first_r     <= have_r ? first_h : '0;
      last_r      <= have_r ? last_h : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.found         = found_r;
  assign out_ch.exact_iface   = exact_out_r;
  assign out_ch.entry_slot    = slot_r;
  assign out_ch.net_address   = net_r;
  assign out_ch.entry_mask    = mask_r;
  assign out_ch.entry_iface   = iface_r;
  assign out_ch.bcast_address = bcast_r;
  assign out_ch.host_min      = first_r;
  assign out_ch.host_max      = last_r;

endmodule

>>> rtl/sstl_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module sstl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/sstl_checker.sv
`include "subnet_scope_table_lookup_defines.svh"

module sstl_checker import sstl_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input logic  out_status,
  input logic  out_found,
  input logic  out_exact_iface,
  input slot_t out_entry_slot,
  input addr_t out_net_address,
  input addr_t out_entry_mask,
  input addr_t out_entry_iface,
  input addr_t out_bcast_address,
  input addr_t out_host_min,
  input addr_t out_host_max
);

  logic                         stalled;
  logic                         flags_ok;
  logic                         fields_zero;
  logic [3+SLOT_W+6*ADDR_W-1:0] held_word;

  // whole result word, for the hold check
  assign stalled   = out_valid && !out_ready;
  assign held_word = {out_status, out_found, out_exact_iface, out_entry_slot, out_net_address,
                      out_entry_mask, out_entry_iface, out_bcast_address, out_host_min,
                      out_host_max};

  // exact interface match implies a match, and full status implies none
  assign flags_ok = (!out_exact_iface || out_found) && (!out_status || !out_found);

  // all scope fields zero
  assign fields_zero = (out_entry_slot == '0) && (out_net_address == '0) &&
                       (out_entry_mask == '0) && (out_entry_iface == '0) &&
                       (out_bcast_address == '0) && (out_host_min == '0) &&
                       (out_host_max == '0);

  // a stalled result word holds
  `SSTL_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(held_word), "stalled result changed")

  // one word in flight: ready drops right after acceptance
  `SSTL_ASSERT_NEXT(a_one_busy, in_valid && in_ready, !in_ready, "second word taken while busy")

  // result flags agree with each other
  `SSTL_ASSERT_NOW(a_flags, out_valid, flags_ok, "inconsistent result flags")

  // a word without a match carries only zero fields
  `SSTL_ASSERT_NOW(a_zero, out_valid && !out_found, fields_zero, "nonzero fields without match")

endmodule

bind subnet_scope_table_lookup sstl_checker u_sstl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_found         (out_ch.found),
  .out_exact_iface   (out_ch.exact_iface),
  .out_entry_slot    (out_ch.entry_slot),
  .out_net_address   (out_ch.net_address),
  .out_entry_mask    (out_ch.entry_mask),
  .out_entry_iface   (out_ch.entry_iface),
  .out_bcast_address (out_ch.bcast_address),
  .out_host_min      (out_ch.host_min),
  .out_host_max      (out_ch.host_max)
);
